// ----- rtl/core/maws_pkg.sv -----
// Constants and widths shared by the maximum window average search block.
package maws_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int SAMPLE_W    = 16;
    localparam int LEN_W       = 11;
    localparam int AVG_W       = 26;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int IDX_W       = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;
    localparam int DIFF_W      = AVG_W + 1;
    localparam int ACC_W       = DIFF_W + CNT_W;
    localparam int TDATA_W     = ((AVG_W + 7) / 8) * 8;

    localparam logic [AVG_W-1:0] MILLI  = AVG_W'(1000);
    localparam logic [AVG_W-1:0] T_HIGH = AVG_W'(65535000);

endpackage

// ----- rtl/core/max_average_window_search_top.sv -----
// Maximum window average search: sample store, bisection and store walk.
//
//  channel  dir  handshake             payload
//  s_       in   s_tvalid / s_tready   s_tdata[15:0] sample, s_tlast end of sequence
//  m_       out  m_tvalid / m_tready   m_tdata[25:0] average x1000, m_tuser too_short/overflowed
//  cfg_     in   cfg_valid / cfg_ready cfg_data[10:0] min_length
//
// Samples load at one beat per cycle. After the last beat the search runs about
// 26 bisection probes; each probe walks the n stored samples through one memory with
// two read ports.
// Reset is synchronous on aresetn low and clears counters, flags and the state machine.
// s_tready is low while the search runs; the result register holds until m_tready.
module max_average_window_search_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [15:0]                      s_tdata,   // [15:0] sample
    input  logic                             s_tlast,   // is_last
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [maws_pkg::TDATA_W-1:0]     m_tdata,   // [25:0] best_average_milli
    output logic [1:0]                       m_tuser,   // [0] too_short, [1] overflowed
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [maws_pkg::LEN_W-1:0]       cfg_data   // min_length
);
    import maws_pkg::*;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SETUP,
        ST_WALK,
        ST_POST
    } state_t;

    state_t                    state_reg;
    logic [LEN_W-1:0]          min_length_reg;
    logic [CNT_W-1:0]          count_reg;
    logic                      ovf_reg;

    logic [SAMPLE_W-1:0]       store_mem [MAX_SAMPLES];
    logic [SAMPLE_W-1:0]       rd_a_reg;
    logic [SAMPLE_W-1:0]       rd_b_reg;

    logic [IDX_W-1:0]          n_reg;
    logic [IDX_W-1:0]          k_reg;
    logic [IDX_W-1:0]          i_reg;
    logic [AVG_W-1:0]          lo_reg;
    logic [AVG_W-1:0]          hi_reg;
    logic [AVG_W-1:0]          t_reg;

    logic                      v1_reg, v2_reg, v3_reg;
    logic                      chk1_reg, chk2_reg, chk3_reg;
    logic                      lag1_reg, lag2_reg;
    logic signed [DIFF_W-1:0]  da_reg;
    logic signed [DIFF_W-1:0]  db_reg;
    logic signed [ACC_W-1:0]   cur_reg;
    logic signed [ACC_W-1:0]   lag_reg;
    logic signed [ACC_W-1:0]   lag_min_reg;
    logic                      found_reg;

    logic                      m_tvalid_reg;
    logic [AVG_W-1:0]          best_reg;
    logic                      too_short_reg;
    logic                      ovf_out_reg;

    logic                      s_accept;
    logic                      store_we;
    logic [CNT_W-1:0]          count_next;
    logic [IDX_W-1:0]          k_next;
    logic                      issue;
    logic [ADDR_W-1:0]         addr_a;
    logic [ADDR_W-1:0]         addr_b;
    logic [IDX_W-1:0]          idx_b;
    logic [AVG_W:0]            span;
    logic [AVG_W-1:0]          mid;
    logic [AVG_W-1:0]          prod_a;
    logic [AVG_W-1:0]          prod_b;
    logic signed [ACC_W-1:0]   lag_next;
    logic                      out_free;
    logic                      drained;

    assign s_tready  = (state_reg == ST_LOAD);
    assign cfg_ready = 1'b1;
    assign s_accept  = s_tvalid && s_tready;
    assign store_we  = s_accept && (count_reg < CNT_W'(MAX_SAMPLES));

    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = TDATA_W'(best_reg);
    assign m_tuser   = {ovf_out_reg, too_short_reg};
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb begin
        count_next = store_we ? count_reg + CNT_W'(1) : count_reg;
        k_next     = (min_length_reg == '0) ? IDX_W'(1) : IDX_W'(min_length_reg);
        issue      = (state_reg == ST_WALK) && (i_reg <= n_reg);
        addr_a     = ADDR_W'(i_reg - IDX_W'(1));
        idx_b      = i_reg - k_reg - IDX_W'(1);
        addr_b     = idx_b[ADDR_W-1:0];
        span       = {1'b0, hi_reg} - {1'b0, lo_reg} + (AVG_W+1)'(1);
        mid        = lo_reg + span[AVG_W:1];
        prod_a     = AVG_W'(rd_a_reg) * MILLI;
        prod_b     = AVG_W'(rd_b_reg) * MILLI;
        lag_next   = lag_reg + ACC_W'(db_reg);
        drained    = !issue && !v1_reg && !v2_reg && !v3_reg;
    end

    // Sample store: one write port for loading, two registered read ports for the walk.
    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_mem[count_reg[ADDR_W-1:0]] <= s_tdata;
        end
        rd_a_reg <= store_mem[addr_a];
        rd_b_reg <= store_mem[addr_b];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_LOAD;
            min_length_reg <= LEN_W'(1);
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            found_reg      <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                min_length_reg <= cfg_data;
            end
            if (m_tvalid_reg && m_tready && (state_reg != ST_POST)) begin
                m_tvalid_reg <= 1'b0;
            end

            // Walk pipeline: read, scale by 1000 and subtract t, accumulate, compare.
            v1_reg   <= issue;
            chk1_reg <= (i_reg >= k_reg);
            lag1_reg <= (i_reg > k_reg);
            v2_reg   <= v1_reg;
            chk2_reg <= chk1_reg;
            lag2_reg <= lag1_reg;
            da_reg   <= $signed({1'b0, prod_a}) - $signed({1'b0, t_reg});
            db_reg   <= $signed({1'b0, prod_b}) - $signed({1'b0, t_reg});
            v3_reg   <= v2_reg;
            chk3_reg <= chk2_reg;
            if (v2_reg) begin
                cur_reg <= cur_reg + ACC_W'(da_reg);
                if (lag2_reg) begin
                    lag_reg <= lag_next;
                    if (lag_next < lag_min_reg) begin
                        lag_min_reg <= lag_next;
                    end
                end
            end
            if (v3_reg && chk3_reg && (cur_reg >= lag_min_reg)) begin
                found_reg <= 1'b1;
            end

            unique case (state_reg)
                ST_LOAD: begin
                    if (s_accept) begin
                        count_reg <= count_next;
                        if (!store_we) begin
                            ovf_reg <= 1'b1;
                        end
                        if (s_tlast) begin
                            n_reg  <= IDX_W'(count_next);
                            k_reg  <= k_next;
                            lo_reg <= '0;
                            hi_reg <= T_HIGH;
                            if (IDX_W'(count_next) < k_next) begin
                                state_reg <= ST_POST;
                            end else begin
                                state_reg <= ST_SETUP;
                            end
                        end
                    end
                end
                ST_SETUP: begin
                    if (lo_reg < hi_reg) begin
                        t_reg       <= mid;
                        i_reg       <= IDX_W'(1);
                        cur_reg     <= '0;
                        lag_reg     <= '0;
                        lag_min_reg <= '0;
                        found_reg   <= 1'b0;
                        state_reg   <= ST_WALK;
                    end else begin
                        state_reg <= ST_POST;
                    end
                end
                ST_WALK: begin
                    if (issue) begin
                        i_reg <= i_reg + IDX_W'(1);
                    end
                    if (drained) begin
                        if (found_reg) begin
                            lo_reg <= t_reg;
                        end else begin
                            hi_reg <= t_reg - AVG_W'(1);
                        end
                        state_reg <= ST_SETUP;
                    end
                end
                ST_POST: begin
                    // The result fields change only once the previous beat has left.
                    // A too-short sequence reaches this state with lo_reg still zero.
                    if (out_free) begin
                        m_tvalid_reg  <= 1'b1;
                        best_reg      <= lo_reg;
                        too_short_reg <= (n_reg < k_reg);
                        ovf_out_reg   <= ovf_reg;
                        count_reg     <= '0;
                        ovf_reg       <= 1'b0;
                        state_reg     <= ST_LOAD;
                    end
                end
                default: begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    a_no_store_write_in_search: assert property (@(posedge aclk) disable iff (!aresetn)
        store_we |-> (state_reg == ST_LOAD))
        else $error("sample store written outside the load phase");

    a_bounds_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SETUP) |-> (lo_reg <= hi_reg))
        else $error("bisection bounds crossed");

    a_found_from_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(found_reg) |-> ($past(state_reg) == ST_WALK))
        else $error("window hit flagged outside a store walk");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_SAMPLES))
        else $error("sample count beyond store depth");

    a_result_after_post: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_POST))
        else $error("result beat raised outside the post state");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the maximum window average search block.
`timescale 1ns / 1ps

module tb_top;
    import maws_pkg::*;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                is_last;
    } sample_beat_t;

    typedef struct packed {
        logic [AVG_W-1:0] avg_milli;
        logic             too_short;
        logic             overflowed;
    } window_result_t;

    localparam int STALL_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 40;

    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic [1:0]           m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [LEN_W-1:0]     cfg_data = '0;

    max_average_window_search_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Mirror of the block's sequence state and its one register.
    logic [SAMPLE_W-1:0] mirror_store [0:MAX_SAMPLES-1];
    int                  mirror_count = 0;
    logic                mirror_overflow = 1'b0;
    logic [LEN_W-1:0]    mirror_min_len = LEN_W'(1);

    sample_beat_t   beats_to_send [$];
    window_result_t awaited_results [$];

    bit calm = 1'b0;
    int send_gap = 0;
    int recv_stall = 0;
    int mismatch_count = 0;
    int result_no = 0;
    int quiet_cycles = 0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    task automatic flag_mismatch(input string field, input longint got, input longint want);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("result %0d: %s is %0d, wanted %0d", result_no, field, got, want);
    endtask

    // Greatest floor(1000 * average) over windows of at least min_len samples,
    // found by trying every window against prefix sums.
    function automatic window_result_t best_window(input int n, input int min_len,
                                                   input logic ovf);
        longint prefix [0:MAX_SAMPLES];
        longint best;
        longint milli;
        int i;
        int e;
        int s;
        window_result_t r;
        r = '0;
        r.overflowed = ovf;
        if (n < min_len) begin
            r.too_short = 1'b1;
            return r;
        end
        prefix[0] = 0;
        for (i = 0; i < n; i++)
            prefix[i + 1] = prefix[i] + longint'(mirror_store[i]);
        best = 0;
        for (e = min_len; e <= n; e++) begin
            for (s = 0; s <= e - min_len; s++) begin
                milli = (longint'(MILLI) * (prefix[e] - prefix[s])) / longint'(e - s);
                if (milli > best)
                    best = milli;
            end
        end
        r.avg_milli = best[AVG_W-1:0];
        return r;
    endfunction

    function automatic void absorb_beat(input logic [SAMPLE_W-1:0] smp, input logic last);
        int min_len;
        min_len = (mirror_min_len == '0) ? 1 : int'(mirror_min_len);
        if (mirror_count < MAX_SAMPLES) begin
            mirror_store[mirror_count] = smp;
            mirror_count++;
        end else begin
            mirror_overflow = 1'b1;
        end
        if (last) begin
            awaited_results.push_back(best_window(mirror_count, min_len, mirror_overflow));
            mirror_count = 0;
            mirror_overflow = 1'b0;
        end
    endfunction

    // Sender: holds a beat until accepted, then takes the next one or idles.
    always @(posedge aclk) begin : sender
        sample_beat_t nb;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                absorb_beat(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (send_gap == 0 && !calm && $urandom_range(0, 9) == 0)
                    send_gap = $urandom_range(1, 12);
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (beats_to_send.size() != 0) begin
                    nb = beats_to_send.pop_front();
                    s_tdata  <= nb.sample;
                    s_tlast  <= nb.is_last;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result beat against the oldest awaited result.
    always @(posedge aclk) begin : receiver
        window_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                result_no++;
                if (awaited_results.size() == 0) begin
                    flag_mismatch("unexpected result, best_average_milli",
                                  m_tdata[AVG_W-1:0], 0);
                end else begin
                    want = awaited_results.pop_front();
                    if (m_tdata[AVG_W-1:0] != want.avg_milli)
                        flag_mismatch("best_average_milli", m_tdata[AVG_W-1:0], want.avg_milli);
                    if (m_tuser[0] != want.too_short)
                        flag_mismatch("too_short", m_tuser[0], want.too_short);
                    if (m_tuser[1] != want.overflowed)
                        flag_mismatch("overflowed", m_tuser[1], want.overflowed);
                end
            end
            if (recv_stall == 0 && !calm && $urandom_range(0, 5) == 0)
                recv_stall = $urandom_range(1, 12);
            if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // A search over a full store runs without a beat on any channel.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic push_beat(input int smp, input bit last);
        sample_beat_t b;
        b.sample  = SAMPLE_W'(smp);
        b.is_last = last;
        beats_to_send.push_back(b);
    endtask

    task automatic push_sequence(input int len, input int style);
        int base;
        int i;
        int v;
        base = $urandom_range(0, 65535);
        for (i = 0; i < len; i++) begin
            case (style)
                0: v = $urandom_range(0, 65535);
                1: v = $urandom_range(0, 15);
                2: v = ($urandom_range(0, 1) != 0) ? 65535 : 0;
                default: begin
                    v = base + $urandom_range(0, 6) - 3;
                    if (v < 0) v = 0;
                    if (v > 65535) v = 65535;
                end
            endcase
            push_beat(v, i == len - 1);
        end
    endtask

    // Only called while the block is idle.
    task automatic set_min_length(input int value);
        @(posedge aclk);
        cfg_data  <= LEN_W'(value);
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        mirror_min_len = LEN_W'(value);
    endtask

    task automatic wait_idle;
        do @(posedge aclk);
        while (beats_to_send.size() != 0 || s_tvalid || awaited_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic random_phase(input int beat_budget);
        int min_len;
        int eff;
        int len;
        int sent;
        case ($urandom_range(0, 4))
            0: min_len = 1;
            1: min_len = 2;
            2: min_len = $urandom_range(1, 6);
            3: min_len = $urandom_range(3, 16);
            default: min_len = 0;
        endcase
        set_min_length(min_len);
        eff = (min_len == 0) ? 1 : min_len;
        sent = 0;
        while (sent < beat_budget) begin
            if (eff > 1 && $urandom_range(0, 7) == 0)
                len = $urandom_range(1, eff - 1);
            else
                len = $urandom_range(eff, eff + 14);
            push_sequence(len, $urandom_range(0, 3));
            sent += len;
        end
        wait_idle();
    endtask

    initial begin : stimulus
        int ph;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Single extreme samples, a spike in zeros, a rising two-sample sequence.
        set_min_length(1);
        push_beat(65535, 1);
        push_beat(0, 1);
        push_beat(0, 0); push_beat(65535, 0); push_beat(0, 1);
        push_beat(1, 0); push_beat(2, 1);
        wait_idle();

        // A zero window length behaves as a length of one.
        set_min_length(0);
        push_beat(1, 0); push_beat(2, 1);
        push_beat(7, 1);
        wait_idle();

        // Too short a sequence, a rounded-down third, saturated windows.
        set_min_length(3);
        push_beat(5, 0); push_beat(7, 1);
        push_beat(1, 0); push_beat(1, 0); push_beat(2, 1);
        push_beat(65535, 0); push_beat(65535, 0); push_beat(65535, 0); push_beat(0, 1);
        wait_idle();

        // All-ones register value: every sequence is too short.
        set_min_length(2047);
        push_beat(9, 0); push_beat(9, 1);
        wait_idle();

        for (ph = 0; ph < 2; ph++)
            random_phase(35);

        // A full store at the longest window with the marked beat dropped, then a
        // too-short sequence that must see the flag cleared.
        set_min_length(1024);
        push_sequence(1025, 3);
        push_sequence(3, 0);
        wait_idle();

        random_phase(30);

        calm = 1'b1;
        random_phase(40);

        if (awaited_results.size() != 0)
            flag_mismatch("results never delivered", 0, awaited_results.size());
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
